// ----- rtl/core/ssfb_pkg.sv -----
// package for the seven-segment frame builder
// holds command codes, frame slot indexes, segment table and divide-by-ten helpers
// no dependencies
`default_nettype none

package ssfb_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [5:0][7:0] t_seg_row;   // segment bytes by digit position 0..5
    typedef logic [3:0] t_slot;           // byte slot within one display update

    localparam t_byte CMD_DATA_WRITE = 8'h40;
    localparam t_byte CMD_ADDRESS    = 8'hC0;
    localparam t_byte CMD_CONTROL    = 8'h80;
    localparam t_byte CTRL_ON_BIT    = 8'h08;
    localparam t_byte SEG_BLANK      = 8'h00;

    localparam logic [2:0] LEVEL_RESET = 3'd7;

    // byte slots of one update
    localparam t_slot SLOT_DATA_CMD = 4'd0;
    localparam t_slot SLOT_ADDR_CMD = 4'd1;
    localparam t_slot SLOT_POS2     = 4'd2;
    localparam t_slot SLOT_POS1     = 4'd3;
    localparam t_slot SLOT_POS0     = 4'd4;
    localparam t_slot SLOT_POS5     = 4'd5;
    localparam t_slot SLOT_POS4     = 4'd6;
    localparam t_slot SLOT_POS3     = 4'd7;
    localparam t_slot SLOT_CTRL_CMD = 4'd8;

    // reciprocal of ten, exact for every 16-bit dividend with a shift of 19
    localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    function automatic logic [15:0] div10(input logic [15:0] x);
        logic [31:0] p;
        p = 32'(x) * 32'(DIV10_MUL);
        return 16'(p >> DIV10_SHIFT);
    endfunction

    function automatic logic [3:0] rem10(input logic [15:0] x, input logic [15:0] q);
        logic [15:0] t;
        t = x - ((q << 3) + (q << 1));
        return t[3:0];
    endfunction

    function automatic t_byte seg_code(input logic [3:0] d);
        t_byte s;
        unique case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/seven_segment_frame_builder_top.sv -----
// seven-segment frame builder: decimal conversion pipeline and update serializer
// depends on ssfb_pkg
// path: stage 1 to stage 5, then the serializer row, then the byte-wide output register
// the serializer takes a new update only once the control byte of the last one is loaded
// conversion: four divide-by-ten stages (one reciprocal multiply each) in flight at once
// reset: synchronous active-low i_rst_n clears all valid bits and sets brightness to 7
`default_nettype none

module seven_segment_frame_builder_top (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // configuration
    input  wire                  i_cfg_we,
    input  wire  [2:0]           i_cfg_wdata,
    // input requests
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  wire  [15:0]          i_value,
    // output bytes
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output ssfb_pkg::t_byte      o_command_byte,
    output logic                 o_start_before,
    output logic                 o_stop_after,
    output logic                 o_last_byte
);
    import ssfb_pkg::*;

    // brightness register
    logic [2:0] r_level;

    // stage 1: captured value
    logic        r_s1_val;
    logic [15:0] r_s1_v;
    // stage 2: units digit done, quotient < 6554
    logic        r_s2_val;
    logic [12:0] r_s2_q;
    t_seg_row    r_s2_row;
    // stage 3: tens done, quotient < 656
    logic        r_s3_val;
    logic [9:0]  r_s3_q;
    t_seg_row    r_s3_row;
    // stage 4: hundreds done, quotient < 66
    logic        r_s4_val;
    logic [6:0]  r_s4_q;
    t_seg_row    r_s4_row;
    // stage 5: thousands done, remaining ten-thousands digit < 7
    logic        r_s5_val;
    logic [3:0]  r_s5_q;
    t_seg_row    r_s5_row;
    // serializer
    logic        r_fr_busy;
    t_slot       r_fr_idx;
    t_seg_row    r_fr_row;
    // output register
    logic        r_out_valid;
    t_byte       r_out_byte;
    logic        r_out_start;
    logic        r_out_stop;
    logic        r_out_last;

    // per-stage ready, back to front
    logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, fr_ready;
    logic out_load, fr_step;

    // stage datapath
    logic [15:0] q2, q3, q4, q5;
    logic [3:0]  d2, d3, d4, d5;
    t_seg_row    n_s2_row, n_s3_row, n_s4_row, n_s5_row, n_fr_row;

    // serializer byte
    t_byte n_byte;
    logic  n_start, n_stop, n_last;

    assign out_load = !r_out_valid || !i_out_stall;
    assign fr_step  = r_fr_busy && out_load;
    assign fr_ready = !r_fr_busy || (fr_step && (r_fr_idx == SLOT_CTRL_CMD));
    assign s5_ready = !r_s5_val || fr_ready;
    assign s4_ready = !r_s4_val || s5_ready;
    assign s3_ready = !r_s3_val || s4_ready;
    assign s2_ready = !r_s2_val || s3_ready;
    assign s1_ready = !r_s1_val || s2_ready;

    assign o_in_stall = !s1_ready;

    // one divide by ten per stage; a digit above the units is blank once nothing remains
    always_comb begin
        q2 = div10(r_s1_v);
        d2 = rem10(r_s1_v, q2);
        n_s2_row    = '0;
        n_s2_row[5] = seg_code(d2);

        q3 = div10(16'(r_s2_q));
        d3 = rem10(16'(r_s2_q), q3);
        n_s3_row    = r_s2_row;
        n_s3_row[4] = (r_s2_q != '0) ? seg_code(d3) : SEG_BLANK;

        q4 = div10(16'(r_s3_q));
        d4 = rem10(16'(r_s3_q), q4);
        n_s4_row    = r_s3_row;
        n_s4_row[3] = (r_s3_q != '0) ? seg_code(d4) : SEG_BLANK;

        q5 = div10(16'(r_s4_q));
        d5 = rem10(16'(r_s4_q), q5);
        n_s5_row    = r_s4_row;
        n_s5_row[2] = (r_s4_q != '0) ? seg_code(d5) : SEG_BLANK;

        // top quotient is a single digit; position 0 never lights for 16-bit values
        n_fr_row    = r_s5_row;
        n_fr_row[1] = (r_s5_q != '0) ? seg_code(r_s5_q) : SEG_BLANK;
        n_fr_row[0] = SEG_BLANK;
    end

    // byte and framing for the current slot
    always_comb begin
        n_byte  = SEG_BLANK;
        n_start = 1'b0;
        n_stop  = 1'b0;
        n_last  = 1'b0;
        unique case (r_fr_idx)
            SLOT_DATA_CMD: begin
                n_byte  = CMD_DATA_WRITE;
                n_start = 1'b1;
                n_stop  = 1'b1;
            end
            SLOT_ADDR_CMD: begin
                n_byte  = CMD_ADDRESS;
                n_start = 1'b1;
            end
            SLOT_POS2: n_byte = r_fr_row[2];
            SLOT_POS1: n_byte = r_fr_row[1];
            SLOT_POS0: n_byte = r_fr_row[0];
            SLOT_POS5: n_byte = r_fr_row[5];
            SLOT_POS4: n_byte = r_fr_row[4];
            SLOT_POS3: begin
                n_byte = r_fr_row[3];
                n_stop = 1'b1;
            end
            SLOT_CTRL_CMD: begin
                n_byte  = CMD_CONTROL | CTRL_ON_BIT | {5'b0, r_level};
                n_start = 1'b1;
                n_stop  = 1'b1;
                n_last  = 1'b1;
            end
            default: begin
                n_byte = SEG_BLANK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LEVEL_RESET;
            r_s1_val    <= 1'b0;
            r_s2_val    <= 1'b0;
            r_s3_val    <= 1'b0;
            r_s4_val    <= 1'b0;
            r_s5_val    <= 1'b0;
            r_fr_busy   <= 1'b0;
            r_fr_idx    <= SLOT_DATA_CMD;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_wdata;
            end
            if (s1_ready) begin
                r_s1_val <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_val <= r_s1_val;
            end
            if (s3_ready) begin
                r_s3_val <= r_s2_val;
            end
            if (s4_ready) begin
                r_s4_val <= r_s3_val;
            end
            if (s5_ready) begin
                r_s5_val <= r_s4_val;
            end
            if (fr_ready) begin
                r_fr_busy <= r_s5_val;
                r_fr_idx  <= SLOT_DATA_CMD;
            end else if (fr_step) begin
                r_fr_idx <= r_fr_idx + 4'd1;
            end
            if (out_load) begin
                r_out_valid <= r_fr_busy;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_v <= i_value;
        end
        if (s2_ready && r_s1_val) begin
            r_s2_q   <= q2[12:0];
            r_s2_row <= n_s2_row;
        end
        if (s3_ready && r_s2_val) begin
            r_s3_q   <= q3[9:0];
            r_s3_row <= n_s3_row;
        end
        if (s4_ready && r_s3_val) begin
            r_s4_q   <= q4[6:0];
            r_s4_row <= n_s4_row;
        end
        if (s5_ready && r_s4_val) begin
            r_s5_q   <= q5[3:0];
            r_s5_row <= n_s5_row;
        end
        if (fr_ready && r_s5_val) begin
            r_fr_row <= n_fr_row;
        end
        if (fr_step) begin
            r_out_byte  <= n_byte;
            r_out_start <= n_start;
            r_out_stop  <= n_stop;
            r_out_last  <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command_byte = r_out_byte;
    assign o_start_before = r_out_start;
    assign o_stop_after   = r_out_stop;
    assign o_last_byte    = r_out_last;

    // slot counter never runs past the control command
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fr_idx <= SLOT_CTRL_CMD)
        else $error("frame slot out of range");

    // a held stage 1 request keeps its value
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_val && !s2_ready) |=> (r_s1_val && $stable(r_s1_v)))
        else $error("stage 1 request lost while stalled");

    // last byte of an update is the fully framed control command
    a_last_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_start && r_out_stop && (r_out_byte[7:3] == 5'b10001)))
        else $error("bad framing on last byte");

    // the only start without stop is the address command
    a_addr_framed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_start && !r_out_stop) |-> (r_out_byte == CMD_ADDRESS))
        else $error("unexpected open start condition");

    // a new update is loaded only after the previous one handed out its last byte
    a_frame_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fr_busy && r_fr_idx != SLOT_CTRL_CMD) |=> r_fr_busy)
        else $error("update dropped before its last byte");

endmodule

`default_nettype wire
